### rtl/skts_pkg.sv
// Shared constants and controller/datapath interface types for the sorted key table.
`timescale 1ns / 1ps
`default_nettype none
package skts_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W           = 64;
    localparam int POS_W           = 10;
    localparam int CMD_W           = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic latch_in;
        logic start_search;
        logic probe;
        logic compare;
        logic shift_rd;
        logic shift_wr;
        logic insert;
        logic clear;
        logic refuse;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             lo_lt_hi;
        logic             key_eq;
        logic             ptr_gt_lo;
        logic             out_free;
    } ctrl_stat_t;

endpackage
`default_nettype wire

### rtl/skts_datapath.sv
// Datapath: key/position memories, search bounds, shift pointer and result register.
`timescale 1ns / 1ps
`default_nettype none
module skts_datapath #(
    parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [skts_pkg::CMD_W-1:0]    command,
    input  wire logic [skts_pkg::KEY_W-1:0]    key,
    input  wire skts_pkg::ctrl_cmd_t           cmd,
    output skts_pkg::ctrl_stat_t               stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic [skts_pkg::POS_W-1:0]         position,
    output logic                               status
);
    import skts_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [POS_W-1:0] pos_mem [TABLE_DEPTH];

    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    lo_reg;
    logic [CW-1:0]    hi_reg;
    logic [CW-1:0]    ptr_reg;
    logic [AW-1:0]    mid_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [POS_W-1:0] rd_pos_reg;
    logic             found_reg;
    logic [POS_W-1:0] res_pos_reg;
    logic             status_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic             out_status_reg;

    logic             is_query;
    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid_next;
    logic [CW-1:0]    ptr_dec;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [POS_W-1:0] wr_pos;
    logic             key_lt;
    logic             key_gt;

    assign is_query = (cmd_reg == CMD_QUERY);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, is_query};
    assign mid_next = mid_sum[CW:1];
    assign ptr_dec  = ptr_reg - {{(CW-1){1'b0}}, 1'b1};
    assign key_lt   = $signed(rd_key_reg) < $signed(key_reg);
    assign key_gt   = $signed(rd_key_reg) > $signed(key_reg);

    always_comb
    begin
        rd_addr = cmd.shift_rd ? ptr_dec[AW-1:0] : mid_next[AW-1:0];
        wr_en   = cmd.shift_wr | cmd.insert;
        if (cmd.insert)
        begin
            wr_addr = lo_reg[AW-1:0];
            wr_key  = key_reg;
            wr_pos  = POS_W'(count_reg);
        end
        else
        begin
            wr_addr = ptr_reg[AW-1:0];
            wr_key  = rd_key_reg;
            wr_pos  = rd_pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pos_mem[wr_addr] <= wr_pos;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_pos_reg <= pos_mem[rd_addr];
    end

    // payload and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg     <= command;
            key_reg     <= key;
            found_reg   <= 1'b0;
            res_pos_reg <= '0;
            status_reg  <= 1'b0;
        end
        if (cmd.refuse)
            status_reg <= 1'b1;
        if (cmd.start_search)
        begin
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            ptr_reg <= count_reg;
        end
        if (cmd.probe)
            mid_reg <= mid_next[AW-1:0];
        if (cmd.compare)
        begin
            if (is_query)
            begin
                if (key_lt)
                    lo_reg <= CW'(mid_reg) + CW'(1);
                else if (key_gt)
                    hi_reg <= CW'(mid_reg);
                else
                begin
                    found_reg   <= 1'b1;
                    res_pos_reg <= rd_pos_reg;
                end
            end
            else if (!key_gt)
                lo_reg <= CW'(mid_reg) + CW'(1);
            else
                hi_reg <= CW'(mid_reg);
        end
        if (cmd.shift_wr)
            ptr_reg <= ptr_dec;
        if (cmd.out_load)
        begin
            out_found_reg  <= found_reg;
            out_pos_reg    <= res_pos_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.insert)
                count_reg <= count_reg + CW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.full      = (count_reg == CW'(TABLE_DEPTH));
    assign stat.lo_lt_hi  = (lo_reg < hi_reg);
    assign stat.key_eq    = !key_lt && !key_gt;
    assign stat.ptr_gt_lo = (ptr_reg > lo_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign position  = out_pos_reg;
    assign status    = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (count_reg < CW'(TABLE_DEPTH)))
        else $error("insert into full table");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> (ptr_reg > lo_reg) && (ptr_reg <= count_reg))
        else $error("shift pointer out of range");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |-> (lo_reg < hi_reg) && (hi_reg <= count_reg))
        else $error("probe outside occupied entries");

endmodule
`default_nettype wire

### rtl/skts_controller.sv
// Controller state machine sequencing clear, load-with-insert and binary-search query.
`timescale 1ns / 1ps
`default_nettype none
module skts_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output skts_pkg::ctrl_cmd_t       cmd,
    input  wire skts_pkg::ctrl_stat_t stat
);
    import skts_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_PROBE    = 3'd2;
    localparam logic [2:0] S_COMPARE  = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_INSERT   = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.cmd)
                    CMD_CLEAR:
                        cmd.clear = 1'b1;
                    CMD_LOAD:
                        if (stat.full)
                            cmd.refuse = 1'b1;
                        else
                        begin
                            cmd.start_search = 1'b1;
                            state_next       = S_PROBE;
                        end
                    CMD_QUERY:
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = S_PROBE;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_PROBE:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_COMPARE;
                end
                else if (stat.cmd == CMD_LOAD)
                    state_next = S_SHIFT_RD;
                else
                    state_next = S_DONE;
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                if ((stat.cmd == CMD_QUERY) && stat.key_eq)
                    state_next = S_DONE;
                else
                    state_next = S_PROBE;
            end
            S_SHIFT_RD:
            begin
                if (stat.ptr_gt_lo)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
                else
                    state_next = S_INSERT;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### rtl/sorted_key_table_search.sv
// Top level of the sorted key table: controller plus datapath.
//
// Usage: the input channel (in_valid/in_ready, command, key) takes one
// transaction at a time: clear, load a signed 64-bit key, or query a key.
// Every input transaction gives exactly one output transaction (out_valid/
// out_ready, found, position, status), in order.
// Clear, refused loads and unused codes go from decode straight to the
// result; a query runs binary-search probes until the bounds meet or a
// hit ends it early; a load runs its search, then moves entries up one at
// a time to open the slot and writes the key. The single read port of the
// key memory, one access per probe or per moved entry, paces both. in_ready
// is high only when no transaction is in progress; the next transaction can
// be accepted at the edge after out_valid rises.
// The result sits in an output register: a new transaction is taken while the
// previous result waits; a stalled receiver holds only the next completion.
// Reset empties the table and drops any pending result; memory contents are
// not cleared, and only entries below the entry count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table_search #(
    parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [skts_pkg::CMD_W-1:0] command,
    input  wire logic [skts_pkg::KEY_W-1:0] key,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            found,
    output logic [skts_pkg::POS_W-1:0]      position,
    output logic                            status
);
    import skts_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    skts_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    skts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .key       (key),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .position  (position),
        .status    (status)
    );

endmodule
`default_nettype wire

### tb/key_table_checker.sv
// Checker for the sorted key table: predicts each result, compares it and counts mismatches.
`timescale 1ns / 1ps
module key_table_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [skts_pkg::CMD_W-1:0] command,
    input  logic [skts_pkg::KEY_W-1:0] key,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       found,
    input  logic [skts_pkg::POS_W-1:0] position,
    input  logic                       status,
    output int                         errors,
    output int                         pending
);
    import skts_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             status;
    } answer_t;

    logic signed [KEY_W-1:0] sorted_keys [DEPTH];
    logic [POS_W-1:0]        load_order  [DEPTH];
    int                      stored;
    answer_t                 answers [$];
    answer_t                 want;

    function automatic answer_t table_apply(input logic [CMD_W-1:0] cmd,
                                            input logic signed [KEY_W-1:0] k);
        answer_t a;
        int      lo;
        int      hi;
        int      mid;
        int      slot;
        a = '0;
        case (cmd)
            CMD_CLEAR: stored = 0;
            CMD_LOAD:
            begin
                if (stored >= DEPTH)
                    a.status = 1'b1;
                else
                begin
                    // insert after any equal keys
                    lo = 0;
                    hi = stored;
                    while (lo < hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (sorted_keys[mid] <= k)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    for (slot = stored; slot > lo; slot--)
                    begin
                        sorted_keys[slot] = sorted_keys[slot - 1];
                        load_order[slot]  = load_order[slot - 1];
                    end
                    sorted_keys[lo] = k;
                    load_order[lo]  = stored[POS_W-1:0];
                    stored++;
                end
            end
            CMD_QUERY:
            begin
                lo = 0;
                hi = stored - 1;
                while (lo <= hi && !a.found)
                begin
                    mid = (lo + hi) / 2;
                    if (sorted_keys[mid] < k)
                        lo = mid + 1;
                    else if (sorted_keys[mid] > k)
                        hi = mid - 1;
                    else
                    begin
                        a.found    = 1'b1;
                        a.position = load_order[mid];
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored  = 0;
            errors  = 0;
            answers.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answers.size() == 0)
                    report_mismatch($sformatf("result with none expected: found %0b pos %0d st %0b",
                                              found, position, status));
                else
                begin
                    want = answers.pop_front();
                    if (found !== want.found)
                        report_mismatch($sformatf("found: got %0b, expected %0b",
                                                  found, want.found));
                    if (position !== want.position)
                        report_mismatch($sformatf("position: got %0d, expected %0d",
                                                  position, want.position));
                    if (status !== want.status)
                        report_mismatch($sformatf("status: got %0b, expected %0b",
                                                  status, want.status));
                end
            end
            if (in_valid && in_ready)
                answers.push_back(table_apply(command, $signed(key)));
            pending = answers.size();
        end
    end

endmodule

### tb/testbench.sv
// Testbench top for the sorted key table: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import skts_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int               DEPTH        = TABLE_DEPTH_DEF;
    localparam int               IDLE_LIMIT   = 20000;
    localparam int               TARGET_ITEMS = 1750;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic             out_valid;
    logic             out_ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic             status;
    int               errors;
    int               pending;

    logic             gaps_on;
    logic             stalls_on;
    int               sent_items  = 0;
    int               table_fill  = 0;
    int               idle_cycles = 0;
    logic [KEY_W-1:0] key_pool  [8];
    logic [KEY_W-1:0] fill_keys [DEPTH];

    sorted_key_table_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .position  (position),
        .status    (status)
    );

    key_table_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .position  (position),
        .status    (status),
        .errors    (errors),
        .pending   (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** sorted_key_table_search: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver back-pressure in bursts
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
                @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 9))
            0:       random_key = KEY_MIN;
            1:       random_key = KEY_MAX;
            2:       random_key = '0;
            3:       random_key = '1;
            default: random_key = {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        if (cmd == CMD_CLEAR)
            table_fill = 0;
        else if (cmd == CMD_LOAD && table_fill < DEPTH)
            table_fill++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // small tables with many repeated keys, plus misses, unused codes and stray clears
    task automatic mixed_phase(input int len);
        int               n;
        int               pick;
        logic [KEY_W-1:0] needle;
        for (n = 0; n < 8; n++)
            key_pool[n] = random_key();
        if (table_fill > 40 || $urandom_range(0, 1) == 0)
            send_cmd(CMD_CLEAR, random_key());
        for (n = 0; n < len; n++)
        begin
            pick   = $urandom_range(0, 99);
            needle = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : random_key();
            if (pick < 45 && table_fill < 48)
                send_cmd(CMD_LOAD, needle);
            else if (pick < 92)
            begin
                if ($urandom_range(0, 5) == 0)
                    needle = needle + (($urandom_range(0, 1) == 0) ? 64'd1 : '1);
                send_cmd(CMD_QUERY, needle);
            end
            else if (pick < 97)
                send_cmd(CMD_UNUSED, random_key());
            else
                send_cmd(CMD_CLEAR, random_key());
        end
    endtask

    // ascending loads keep each insert at the end, so filling the table stays cheap
    task automatic full_table_phase();
        int               n;
        logic [31:0]      r_hi;
        logic [31:0]      r_lo;
        logic [KEY_W-1:0] walk;
        logic [KEY_W-1:0] step;
        logic [KEY_W-1:0] needle;
        r_lo = $urandom;
        walk = {KEY_MIN[63:8], r_lo[7:0]};
        send_cmd(CMD_CLEAR, random_key());
        for (n = 0; n < DEPTH; n++)
        begin
            fill_keys[n] = walk;
            send_cmd(CMD_LOAD, walk);
            r_hi = $urandom;
            r_lo = $urandom;
            step = ($urandom_range(0, 3) == 0) ? '0 : {12'd0, r_hi[19:0], r_lo};
            walk = walk + step;
        end
        send_cmd(CMD_LOAD, KEY_MIN);
        send_cmd(CMD_LOAD, KEY_MAX);
        send_cmd(CMD_LOAD, fill_keys[$urandom_range(0, DEPTH - 1)]);
        send_cmd(CMD_LOAD, random_key());
        send_cmd(CMD_QUERY, fill_keys[0]);
        send_cmd(CMD_QUERY, fill_keys[DEPTH - 1]);
        for (n = 0; n < 24; n++)
        begin
            needle = fill_keys[$urandom_range(0, DEPTH - 1)];
            case ($urandom_range(0, 3))
                0:       needle = random_key();
                1:       needle = needle + 64'd1;
                default: ;
            endcase
            send_cmd(CMD_QUERY, needle);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_CLEAR;
        key       = '0;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_cmd(CMD_QUERY, 64'd0);
        send_cmd(CMD_LOAD, 64'd5);
        send_cmd(CMD_LOAD, KEY_MIN);
        send_cmd(CMD_LOAD, KEY_MAX);
        send_cmd(CMD_LOAD, 64'd0);
        send_cmd(CMD_LOAD, '1);
        send_cmd(CMD_LOAD, 64'd5);
        send_cmd(CMD_LOAD, 64'd5);
        send_cmd(CMD_QUERY, 64'd5);
        send_cmd(CMD_QUERY, KEY_MIN);
        send_cmd(CMD_QUERY, KEY_MAX);
        send_cmd(CMD_QUERY, 64'd0);
        send_cmd(CMD_QUERY, '1);
        send_cmd(CMD_QUERY, 64'd6);
        send_cmd(CMD_UNUSED, KEY_MAX);
        send_cmd(CMD_QUERY, 64'd4);
        send_cmd(CMD_CLEAR, '0);
        send_cmd(CMD_QUERY, 64'd5);
        send_cmd(CMD_LOAD, 64'd5);
        send_cmd(CMD_QUERY, 64'd5);
        send_cmd(CMD_UNUSED, KEY_MIN);
        drain_results();

        while (sent_items < 560)
        begin
            gaps_on   = ($urandom_range(0, 1) == 1);
            stalls_on = ($urandom_range(0, 1) == 1);
            mixed_phase($urandom_range(20, 60));
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        full_table_phase();

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        while (sent_items < TARGET_ITEMS)
            mixed_phase($urandom_range(20, 60));

        drain_results();
        repeat (40) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("** sorted_key_table_search: PASSED **");
        else
            $display("** sorted_key_table_search: FAILED **");
        $finish;
    end

endmodule
